// ----- src/fsa_pkg.sv -----
// Shared opcodes, status codes and field widths for the frame stack allocator.
`default_nettype none

package fsa_pkg;

   localparam int OPCODE_W = 2;
   localparam int SIZE_W   = 8;
   localparam int BYTE_W   = 8;
   localparam int RADDR_W  = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

// ----- src/frame_stack_allocator_core.sv -----
// Downward-growing byte stack with a frame size table, built around two memories.
// Allocate of n bytes writes the fill value to each of the n bytes through the byte store's write port, top down.
// Free and read first do the synchronous memory read, then answer from S_FREE or S_READ.
// Refused allocates, refused frees, zero-size allocates and unused opcodes are answered straight from idle.
// After reset a clearing pass zeroes the byte store with busy high.
// The result is strobed on rsp_valid for one cycle and cannot be stalled.
`default_nettype none

module frame_stack_allocator_core #(
   parameter int STORE_DEPTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [fsa_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [fsa_pkg::SIZE_W-1:0]       req_alloc_size,
   input  wire logic [fsa_pkg::BYTE_W-1:0]       req_fill_value,
   input  wire logic [fsa_pkg::RADDR_W-1:0]      req_read_address,
   output logic                                  rsp_valid,
   output logic [fsa_pkg::STATUS_W-1:0]          rsp_status,
   output logic [fsa_pkg::COUNT_W-1:0]           rsp_used_bytes,
   output logic [fsa_pkg::COUNT_W-1:0]           rsp_frames_held,
   output logic [fsa_pkg::BYTE_W-1:0]            rsp_read_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int SW = ((CW > fsa_pkg::SIZE_W) ? CW : fsa_pkg::SIZE_W) + 1;
   localparam logic [AW-1:0] TOP_ADDR = AW'(STORE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(STORE_DEPTH);
   localparam logic [SW-1:0] DEPTH_S  = SW'(STORE_DEPTH);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;

   logic [fsa_pkg::BYTE_W-1:0] byte_mem [STORE_DEPTH];
   logic [CW-1:0]              size_mem [STORE_DEPTH];

   logic [2:0]                   state_ff, state_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic [CW-1:0]                rem_ff, rem_in;
   logic [CW-1:0]                used_ff, used_in;
   logic [CW-1:0]                frames_ff, frames_in;
   logic [fsa_pkg::BYTE_W-1:0]   fill_ff, fill_in;
   logic                         in_range_ff, in_range_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fsa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [fsa_pkg::COUNT_W-1:0]  rsp_used_ff, rsp_used_in;
   logic [fsa_pkg::COUNT_W-1:0]  rsp_frames_ff, rsp_frames_in;
   logic [fsa_pkg::BYTE_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [fsa_pkg::BYTE_W-1:0]   byte_rd_ff;
   logic [CW-1:0]                size_rd_ff;

   logic                         accept;
   logic [SW-1:0]                alloc_sum;
   logic                         alloc_refused;
   logic [CW-1:0]                frames_dec;
   logic [AW-1:0]                byte_raddr;
   logic                         byte_we;
   logic [fsa_pkg::BYTE_W-1:0]   byte_wdata;
   logic                         size_we;

   function automatic logic [fsa_pkg::COUNT_W-1:0] COUNT_W_CAST(input logic [CW-1:0] value);
      return fsa_pkg::COUNT_W'(value);
   endfunction

   assign accept        = start && (state_ff == S_IDLE);
   assign alloc_sum     = SW'(used_ff) + SW'(req_alloc_size);
   assign alloc_refused = (alloc_sum > DEPTH_S) || (frames_ff == DEPTH_C);
   assign frames_dec    = frames_ff - CW'(1);
   assign byte_raddr    = AW'(req_read_address);
   assign byte_we       = (state_ff == S_CLEAR) || (state_ff == S_FILL);
   assign byte_wdata    = (state_ff == S_FILL) ? fill_ff : '0;
   assign size_we       = accept && (req_opcode == fsa_pkg::OP_ALLOC) && !alloc_refused;

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[addr_ff] <= byte_wdata;
      end
      byte_rd_ff <= byte_mem[byte_raddr];
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[frames_ff[AW-1:0]] <= CW'(req_alloc_size);
      end
      size_rd_ff <= size_mem[frames_dec[AW-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      rem_in        = rem_ff;
      used_in       = used_ff;
      frames_in     = frames_ff;
      fill_in       = fill_ff;
      in_range_in   = in_range_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = fsa_pkg::ST_OK;
      rsp_used_in   = rsp_used_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_data_in   = '0;
      unique case (state_ff)
         S_CLEAR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == TOP_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               rsp_used_in   = COUNT_W_CAST(used_ff);
               rsp_frames_in = COUNT_W_CAST(frames_ff);
               unique case (req_opcode)
                  fsa_pkg::OP_ALLOC: begin
                     if (alloc_refused) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fsa_pkg::ST_OVERFLOW;
                     end else begin
                        used_in       = used_ff + CW'(req_alloc_size);
                        frames_in     = frames_ff + CW'(1);
                        addr_in       = TOP_ADDR - AW'(used_ff);
                        rem_in        = CW'(req_alloc_size);
                        fill_in       = req_fill_value;
                        rsp_used_in   = COUNT_W_CAST(used_in);
                        rsp_frames_in = COUNT_W_CAST(frames_in);
                        if (req_alloc_size == '0) begin
                           rsp_valid_in = 1'b1;
                        end else begin
                           state_in = S_FILL;
                        end
                     end
                  end
                  fsa_pkg::OP_FREE: begin
                     if (frames_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fsa_pkg::ST_UNDERFLOW;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  fsa_pkg::OP_READ: begin
                     in_range_in = (32'(req_read_address) < 32'(STORE_DEPTH));
                     state_in    = S_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_FILL: begin
            addr_in = addr_ff - AW'(1);
            rem_in  = rem_ff - CW'(1);
            if (rem_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FREE: begin
            used_in       = (size_rd_ff <= used_ff) ? (used_ff - size_rd_ff) : '0;
            frames_in     = frames_dec;
            rsp_used_in   = COUNT_W_CAST(used_in);
            rsp_frames_in = COUNT_W_CAST(frames_in);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_READ: begin
            rsp_used_in   = COUNT_W_CAST(used_ff);
            rsp_frames_in = COUNT_W_CAST(frames_ff);
            rsp_data_in   = in_range_ff ? byte_rd_ff : '0;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         used_ff      <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         used_ff      <= used_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      fill_ff       <= fill_in;
      in_range_ff   <= in_range_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_used_bytes  = rsp_used_ff;
   assign rsp_frames_held = rsp_frames_ff;
   assign rsp_read_data   = rsp_data_ff;

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (used_ff <= DEPTH_C) && (frames_ff <= DEPTH_C))
      else $error("byte or frame count exceeds the store depth");

   a_free_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE) || (state_ff == S_READ) |=> rsp_valid)
      else $error("free or read did not answer after the memory read");

   a_fill_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) && (rem_ff == CW'(1)) |=> rsp_valid && (state_ff == S_IDLE))
      else $error("fill did not finish with a word");

   a_no_word_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid)
      else $error("word issued during the clearing pass");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == fsa_pkg::ST_UNDERFLOW) |-> (frames_ff == '0))
      else $error("underflow reported with frames held");

endmodule

`default_nettype wire
